[hw/rtl/rsl_pkg.sv]
`timescale 1ns / 1ps

package rsl_pkg;

    localparam int NUM_PIXELS      = 8;
    localparam int TICKS_PER_FRAME = 10;
    localparam int LEVELS          = 8;

    localparam int LOCKOUT_TICKS = 200;
    localparam int SHOW_TICKS    = 500;
    localparam int FLASH_CYCLE   = 600;
    localparam int SLOW_HALF     = 300;
    localparam int FAST_HALF     = 100;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int LEVEL_W   = $clog2(LEVELS);
    localparam int FACTOR_W  = LEVEL_W + 1;
    localparam int PIX_W     = $clog2(NUM_PIXELS);
    localparam int FDIV_W    = (TICKS_PER_FRAME > 1) ? $clog2(TICKS_PER_FRAME) : 1;
    localparam int LOCKOUT_W = 8;
    localparam int SHOW_W    = 9;
    localparam int FLASH_W   = 10;
    localparam int THR_W     = $clog2(65536 + NUM_PIXELS * 8192);

    localparam logic [2:0] CFG_RPM_START     = 3'd0;
    localparam logic [2:0] CFG_RPM_STEP      = 3'd1;
    localparam logic [2:0] CFG_COLOUR_GREEN  = 3'd2;
    localparam logic [2:0] CFG_COLOUR_ORANGE = 3'd3;
    localparam logic [2:0] CFG_COLOUR_RED    = 3'd4;

    typedef enum logic [2:0] {
        FRAME_DARK,
        FRAME_LEVEL,
        FRAME_PIX0_RED,
        FRAME_PIX0_ORANGE,
        FRAME_ALL_RED,
        FRAME_BAR
    } frame_kind_t;

    typedef struct packed {
        frame_kind_t         kind;
        logic [LEVEL_W-1:0]  level;
        logic [15:0]         rpm;
    } frame_desc_t;

    typedef struct packed {
        logic [15:0] rpm_start;
        logic [12:0] rpm_step;
        logic [23:0] colour_green;
        logic [23:0] colour_orange;
        logic [23:0] colour_red;
    } cfg_t;

    function automatic logic [23:0] scale_colour(
        input logic [23:0]         base,
        input logic [FACTOR_W-1:0] factor
    );
        logic [23:0]           res;
        logic [8+FACTOR_W-1:0] prod;
        res = '0;
        for (int c = 0; c < 3; c++)
        begin
            prod = (8 + FACTOR_W)'(base[c*8 +: 8]) * (8 + FACTOR_W)'(factor);
            res[c*8 +: 8] = (prod > (8 + FACTOR_W)'(255)) ? 8'hFF : prod[7:0];
        end
        return res;
    endfunction

endpackage

[hw/rtl/rsl_front.sv]
`timescale 1ns / 1ps

module rsl_front import rsl_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        button_down,
    input  logic        ecu_valid,
    input  logic [15:0] engine_rpm,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output cfg_t        cfg,
    output logic        q_push,
    output frame_desc_t q_push_data,
    input  logic        q_full
);

    cfg_t                 cfg_reg;
    logic [LEVEL_W-1:0]   level_reg,   level_next;
    logic [LOCKOUT_W-1:0] lockout_reg, lockout_next;
    logic [SHOW_W-1:0]    show_reg,    show_next;
    logic [FLASH_W-1:0]   flash_reg,   flash_next;
    logic [FDIV_W-1:0]    fdiv_reg,    fdiv_next;

    logic             accept;
    logic             pressed;
    logic             frame_tick;
    logic             show_frame;
    logic             slow_on;
    logic             fast_on;
    logic [THR_W-1:0] top;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rpm_start     <= 16'd4100;
            cfg_reg.rpm_step      <= 13'd300;
            cfg_reg.colour_green  <= 24'h100000;
            cfg_reg.colour_orange <= 24'h081000;
            cfg_reg.colour_red    <= 24'h001000;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_RPM_START:     cfg_reg.rpm_start     <= cfg_data[15:0];
                CFG_RPM_STEP:      cfg_reg.rpm_step      <= cfg_data[12:0];
                CFG_COLOUR_GREEN:  cfg_reg.colour_green  <= cfg_data;
                CFG_COLOUR_ORANGE: cfg_reg.colour_orange <= cfg_data;
                CFG_COLOUR_RED:    cfg_reg.colour_red    <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign frame_tick = (fdiv_reg == '0);
    assign in_ready   = !frame_tick || !q_full;
    assign accept     = in_valid && in_ready;
    assign pressed    = (lockout_reg == '0) && button_down;
    assign show_frame = pressed || (show_reg != '0);
    assign slow_on    = flash_reg < FLASH_W'(SLOW_HALF);
    assign fast_on    = (flash_reg < FLASH_W'(FAST_HALF))
                     || ((flash_reg >= FLASH_W'(2 * FAST_HALF))
                         && (flash_reg < FLASH_W'(3 * FAST_HALF)))
                     || ((flash_reg >= FLASH_W'(4 * FAST_HALF))
                         && (flash_reg < FLASH_W'(5 * FAST_HALF)));
    assign top = THR_W'(cfg_reg.rpm_start)
               + THR_W'(cfg_reg.rpm_step) * THR_W'(NUM_PIXELS);

    always_comb
    begin
        level_next   = level_reg;
        lockout_next = lockout_reg;
        if (lockout_reg != '0)
        begin
            lockout_next = lockout_reg - 1'b1;
        end
        else if (button_down)
        begin
            lockout_next = LOCKOUT_W'(LOCKOUT_TICKS - 1);
            level_next   = (level_reg == LEVEL_W'(LEVELS - 1)) ? '0 : level_reg + 1'b1;
        end

        if (pressed)
        begin
            show_next = SHOW_W'(SHOW_TICKS - 1);
        end
        else if (show_reg != '0)
        begin
            show_next = show_reg - 1'b1;
        end
        else
        begin
            show_next = '0;
        end

        flash_next = (flash_reg == FLASH_W'(FLASH_CYCLE - 1)) ? '0 : flash_reg + 1'b1;
        fdiv_next  = (fdiv_reg == FDIV_W'(TICKS_PER_FRAME - 1)) ? '0 : fdiv_reg + 1'b1;
    end

    always_comb
    begin
        q_push_data.level = level_next;
        q_push_data.rpm   = engine_rpm;
        priority if (show_frame)
        begin
            q_push_data.kind = FRAME_LEVEL;
        end
        else if (!ecu_valid)
        begin
            q_push_data.kind = slow_on ? FRAME_PIX0_RED : FRAME_DARK;
        end
        else if (engine_rpm == '0)
        begin
            q_push_data.kind = slow_on ? FRAME_PIX0_ORANGE : FRAME_DARK;
        end
        else if (THR_W'(engine_rpm) >= top)
        begin
            q_push_data.kind = fast_on ? FRAME_ALL_RED : FRAME_DARK;
        end
        else
        begin
            q_push_data.kind = FRAME_BAR;
        end
    end

    assign q_push = accept && frame_tick;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg   <= '0;
            lockout_reg <= '0;
            show_reg    <= '0;
            flash_reg   <= '0;
            fdiv_reg    <= '0;
        end
        else if (accept)
        begin
            level_reg   <= level_next;
            lockout_reg <= lockout_next;
            show_reg    <= show_next;
            flash_reg   <= flash_next;
            fdiv_reg    <= fdiv_next;
        end
    end

    a_lockout_range: assert property (@(posedge clk) disable iff (!rst_n)
        lockout_reg < LOCKOUT_W'(LOCKOUT_TICKS))
        else $error("lockout counter out of range");

    a_flash_range: assert property (@(posedge clk) disable iff (!rst_n)
        flash_reg < FLASH_W'(FLASH_CYCLE))
        else $error("flash phase out of range");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("frame pushed into a full queue");

endmodule

[hw/rtl/rsl_queue.sv]
`timescale 1ns / 1ps

module rsl_queue import rsl_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  frame_desc_t push_data,
    output logic        full,
    output logic        pop_valid,
    output frame_desc_t pop_data,
    input  logic        pop
);

    frame_desc_t       entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

[hw/rtl/rsl_back.sv]
`timescale 1ns / 1ps

module rsl_back import rsl_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_valid,
    input  frame_desc_t q_data,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  pixel_index,
    output logic [23:0] pixel_colour,
    output logic        frame_last
);

    frame_desc_t      desc_reg;
    logic             busy_reg,   busy_next;
    logic [PIX_W-1:0] pix_reg,    pix_next;
    logic [THR_W-1:0] thr_reg,    thr_next;
    logic             out_valid_reg, out_valid_next;
    logic [2:0]       index_reg;
    logic [23:0]      colour_reg;
    logic             last_reg;

    logic             adv;
    logic             last_pix;
    logic             load;
    logic             lit;
    logic [23:0]      base;
    logic [23:0]      colour;
    logic [PIX_W+3:0] pix_x8;

    assign adv      = busy_reg && (!out_valid_reg || out_ready);
    assign last_pix = (pix_reg == PIX_W'(NUM_PIXELS - 1));
    assign load     = !busy_reg || (adv && last_pix);
    assign q_pop    = load && q_valid;
    assign pix_x8   = (PIX_W + 4)'(pix_reg) << 3;

    always_comb
    begin
        if (pix_x8 < (PIX_W + 4)'(3 * NUM_PIXELS))
        begin
            base = cfg.colour_green;
        end
        else if (pix_x8 < (PIX_W + 4)'(6 * NUM_PIXELS))
        begin
            base = cfg.colour_orange;
        end
        else
        begin
            base = cfg.colour_red;
        end
        lit = 1'b0;
        unique case (desc_reg.kind)
            FRAME_DARK:
            begin
                lit = 1'b0;
            end
            FRAME_LEVEL:
            begin
                lit  = (PIX_W + LEVEL_W)'(pix_reg) <= (PIX_W + LEVEL_W)'(desc_reg.level);
                base = cfg.colour_green;
            end
            FRAME_PIX0_RED:
            begin
                lit  = (pix_reg == '0);
                base = cfg.colour_red;
            end
            FRAME_PIX0_ORANGE:
            begin
                lit  = (pix_reg == '0);
                base = cfg.colour_orange;
            end
            FRAME_ALL_RED:
            begin
                lit  = 1'b1;
                base = cfg.colour_red;
            end
            FRAME_BAR:
            begin
                lit = THR_W'(desc_reg.rpm) >= thr_reg;
            end
            default:
            begin
                lit = 1'b0;
            end
        endcase
        colour = lit ? scale_colour(base, FACTOR_W'(desc_reg.level) + 1'b1) : '0;
    end

    always_comb
    begin
        busy_next = busy_reg;
        pix_next  = pix_reg;
        thr_next  = thr_reg;
        if (load)
        begin
            busy_next = q_valid;
            pix_next  = '0;
            thr_next  = THR_W'(cfg.rpm_start);
        end
        else if (adv)
        begin
            pix_next = pix_reg + 1'b1;
            thr_next = thr_reg + THR_W'(cfg.rpm_step);
        end

        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
        thr_reg <= thr_next;
        if (q_pop)
        begin
            desc_reg <= q_data;
        end
        if (adv)
        begin
            index_reg  <= 3'(pix_reg);
            colour_reg <= colour;
            last_reg   <= last_pix;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_index  = index_reg;
    assign pixel_colour = colour_reg;
    assign frame_last   = last_reg;

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> (index_reg == 3'(NUM_PIXELS - 1)))
        else $error("frame end on a pixel that is not the last one");

    a_pop_only_at_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && busy_reg) |-> (adv && last_pix))
        else $error("new frame taken while a frame is still in progress");

endmodule

[hw/rtl/rpm_shift_light_bar.sv]
`timescale 1ns / 1ps

// Shift-light bar: each input transfer is one 1 ms tick carrying the button level, the engine
// controller valid flag and the engine rpm. Every tenth tick, starting with the first after
// reset, the block delivers one frame of eight pixel transfers in pixel order, with frame_last
// on the final one; all other ticks deliver nothing. Ticks may follow in every cycle; only a
// frame tick waits, while the two-entry frame queue is full. The pixel generator produces one
// pixel per cycle while out_ready is high, and starts the next queued frame straight after
// the last pixel of the one before. Configuration writes are taken in every cycle and must
// only be issued while no frame is pending.
module rpm_shift_light_bar import rsl_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        button_down,
    input  logic        ecu_valid,
    input  logic [15:0] engine_rpm,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  pixel_index,
    output logic [23:0] pixel_colour,
    output logic        frame_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    cfg_t        cfg;
    logic        q_push;
    frame_desc_t q_push_data;
    logic        q_full;
    logic        q_valid;
    frame_desc_t q_data;
    logic        q_pop;

    rsl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .button_down (button_down),
        .ecu_valid   (ecu_valid),
        .engine_rpm  (engine_rpm),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cfg         (cfg),
        .q_push      (q_push),
        .q_push_data (q_push_data),
        .q_full      (q_full)
    );

    rsl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_data  (q_data),
        .pop       (q_pop)
    );

    rsl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_index  (pixel_index),
        .pixel_colour (pixel_colour),
        .frame_last   (frame_last)
    );

endmodule
